@@ rtl/bpfv_pkg.sv @@
package bpfv_pkg;

   localparam int MODE_W = 4;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int PAL_ADDR_W = 10;
   localparam int PAL_DEPTH = 1 << PAL_ADDR_W;

   localparam logic [MODE_W-1:0] MODE_WIN_RD   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_WIN_WR   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_LATCH_RD = 4'd2;
   localparam logic [MODE_W-1:0] MODE_LATCH_WR = 4'd3;
   localparam logic [MODE_W-1:0] MODE_LATCH_HI = 4'd4;
   localparam logic [MODE_W-1:0] MODE_LATCH_LO = 4'd5;
   localparam logic [MODE_W-1:0] MODE_PAL_WR   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BANK_WR  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_PIXEL    = 4'd8;

   // RRGGBBII level table, indexed by {color bits, intensity bits}
   localparam logic [DATA_W-1:0] LEVEL_TABLE [16] = '{
      8'h00, 8'h12, 8'h24, 8'h49,
      8'h12, 8'h24, 8'h49, 8'h92,
      8'h5b, 8'h6d, 8'h92, 8'hdb,
      8'h7f, 8'h91, 8'hb6, 8'hff
   };

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } frame_req_type;

   typedef struct packed {
      logic                  we;
      logic                  re;
      logic [PAL_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]     data;
   } pal_req_type;

   function automatic logic [DATA_W-1:0] level_of(input logic [1:0] bits,
                                                  input logic [1:0] inten);
      return LEVEL_TABLE[{bits, inten}];
   endfunction

endpackage

@@ rtl/bpfv_frame_mem.sv @@
module bpfv_frame_mem (
   input  logic                         clock,
   input  bpfv_pkg::frame_req_type      req,
   output logic [bpfv_pkg::DATA_W-1:0]  rdata
);

   logic [bpfv_pkg::DATA_W-1:0] mem_ff [1 << bpfv_pkg::ADDR_W];
   logic [bpfv_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.addr] <= req.data;
      end
      if (req.re) begin
         rdata_ff <= mem_ff[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bpfv_pal_mem.sv @@
module bpfv_pal_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  bpfv_pkg::pal_req_type        req,
   output logic [bpfv_pkg::DATA_W-1:0]  rdata,
   output logic                         clear_done
);

   logic [bpfv_pkg::DATA_W-1:0]   mem_ff [bpfv_pkg::PAL_DEPTH];
   logic [bpfv_pkg::DATA_W-1:0]   rdata_ff;
   logic [bpfv_pkg::PAL_ADDR_W:0] clr_cnt_ff;
   logic [bpfv_pkg::PAL_ADDR_W:0] clr_cnt_in;
   logic                          clearing;

   assign clearing = !clr_cnt_ff[bpfv_pkg::PAL_ADDR_W];
   assign clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // sweep zeros after reset, then serve the sequencer
   always_ff @(posedge clock) begin
      if (clearing) begin
         mem_ff[clr_cnt_ff[bpfv_pkg::PAL_ADDR_W-1:0]] <= '0;
      end else if (req.we) begin
         mem_ff[req.addr] <= req.data;
      end
      if (req.re) begin
         rdata_ff <= mem_ff[req.addr];
      end
   end

   assign rdata = rdata_ff;
   assign clear_done = !clearing;

endmodule

@@ rtl/banked_palette_framebuffer_video_core.sv @@
// Banked-palette frame store video core. One request beat in, one response beat out. Bus
// accesses (window/latch reads and writes, latch, palette and bank writes) pass from accept
// through the registered frame store read (ST_FRAME) to the response register, and a pixel
// lookup adds the registered palette RAM read (ST_PAL) in between; both wait while the response
// register is held by rsp_ready. The next request is taken only once the response is registered.
// After reset the palette RAM is swept to zero, during which req_ready stays low.
// A read of a frame store byte that was never written returns an undefined value.
module banked_palette_framebuffer_video_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bpfv_pkg::MODE_W-1:0]         req_mode,
   input  logic [bpfv_pkg::ADDR_W-1:0]         req_address,
   input  logic [bpfv_pkg::DATA_W-1:0]         req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpfv_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [bpfv_pkg::DATA_W-1:0]         rsp_red,
   output logic [bpfv_pkg::DATA_W-1:0]         rsp_green,
   output logic [bpfv_pkg::DATA_W-1:0]         rsp_blue
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FRAME = 2'd1;
   localparam logic [1:0] ST_PAL   = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [bpfv_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [bpfv_pkg::DATA_W-1:0]   latch_high_ff, latch_high_in;
   logic [bpfv_pkg::DATA_W-1:0]   latch_low_ff, latch_low_in;
   logic [bpfv_pkg::DATA_W-1:0]   bank_ff, bank_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bpfv_pkg::DATA_W-1:0]   rsp_read_data_ff, rsp_read_data_in;
   logic [bpfv_pkg::DATA_W-1:0]   rsp_red_ff, rsp_red_in;
   logic [bpfv_pkg::DATA_W-1:0]   rsp_green_ff, rsp_green_in;
   logic [bpfv_pkg::DATA_W-1:0]   rsp_blue_ff, rsp_blue_in;

   bpfv_pkg::frame_req_type       frame_req;
   bpfv_pkg::pal_req_type         pal_req;
   logic [bpfv_pkg::DATA_W-1:0]   frame_rdata;
   logic [bpfv_pkg::DATA_W-1:0]   pal_rdata;
   logic                          pal_ready;
   logic                          accept;
   logic                          out_free;
   logic                          load;

   bpfv_frame_mem u_frame (
      .clock (clock),
      .req   (frame_req),
      .rdata (frame_rdata)
   );

   bpfv_pal_mem u_pal (
      .clock      (clock),
      .reset      (reset),
      .req        (pal_req),
      .rdata      (pal_rdata),
      .clear_done (pal_ready)
   );

   assign req_ready = (state_ff == ST_IDLE) && pal_ready;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      mode_in          = mode_ff;
      latch_high_in    = latch_high_ff;
      latch_low_in     = latch_low_ff;
      bank_in          = bank_ff;
      load             = 1'b0;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_red_in       = rsp_red_ff;
      rsp_green_in     = rsp_green_ff;
      rsp_blue_in      = rsp_blue_ff;
      frame_req        = '0;
      pal_req          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in        = req_mode;
               state_in       = ST_FRAME;
               frame_req.data = req_write_data;
               pal_req.data   = req_write_data;
               pal_req.addr   = req_address[bpfv_pkg::PAL_ADDR_W-1:0];
               case (req_mode)
                  bpfv_pkg::MODE_WIN_RD, bpfv_pkg::MODE_WIN_WR: begin
                     frame_req.addr = {latch_high_ff[7], req_address[14:0]};
                  end
                  bpfv_pkg::MODE_LATCH_RD, bpfv_pkg::MODE_LATCH_WR: begin
                     frame_req.addr = {latch_high_ff, latch_low_ff};
                  end
                  default: begin
                     frame_req.addr = req_address;
                  end
               endcase
               frame_req.we = (req_mode == bpfv_pkg::MODE_WIN_WR) ||
                              (req_mode == bpfv_pkg::MODE_LATCH_WR);
               frame_req.re = (req_mode == bpfv_pkg::MODE_WIN_RD) ||
                              (req_mode == bpfv_pkg::MODE_LATCH_RD) ||
                              (req_mode == bpfv_pkg::MODE_PIXEL);
               pal_req.we   = (req_mode == bpfv_pkg::MODE_PAL_WR);
               if (req_mode == bpfv_pkg::MODE_LATCH_HI) begin
                  latch_high_in = req_write_data;
               end
               if (req_mode == bpfv_pkg::MODE_LATCH_LO) begin
                  latch_low_in = req_write_data;
               end
               if (req_mode == bpfv_pkg::MODE_BANK_WR) begin
                  bank_in = req_write_data;
               end
            end
         end
         ST_FRAME: begin
            if (mode_ff == bpfv_pkg::MODE_PIXEL) begin
               // pen from the frame store picks the entry in the active page
               pal_req.re   = 1'b1;
               pal_req.addr = {bank_ff[1:0], frame_rdata};
               state_in     = ST_PAL;
            end else if (out_free) begin
               load             = 1'b1;
               rsp_read_data_in = ((mode_ff == bpfv_pkg::MODE_WIN_RD) ||
                                   (mode_ff == bpfv_pkg::MODE_LATCH_RD)) ? frame_rdata : '0;
               rsp_red_in       = '0;
               rsp_green_in     = '0;
               rsp_blue_in      = '0;
               state_in         = ST_IDLE;
            end
         end
         ST_PAL: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_read_data_in = '0;
               rsp_red_in       = bpfv_pkg::level_of(pal_rdata[7:6], pal_rdata[1:0]);
               rsp_green_in     = bpfv_pkg::level_of(pal_rdata[5:4], pal_rdata[1:0]);
               rsp_blue_in      = bpfv_pkg::level_of(pal_rdata[3:2], pal_rdata[1:0]);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         latch_high_ff <= '0;
         latch_low_ff  <= '0;
         bank_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         latch_high_ff <= latch_high_in;
         latch_low_ff  <= latch_low_in;
         bank_ff       <= bank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_red_ff       <= rsp_red_in;
      rsp_green_ff     <= rsp_green_in;
      rsp_blue_ff      <= rsp_blue_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;

   a_pal_after_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAL |-> $past(state_ff) == ST_FRAME || $past(state_ff) == ST_PAL)
      else $error("palette stage entered without a frame read");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FRAME || $past(state_ff) == ST_PAL)
      else $error("response raised outside a result stage");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      !pal_ready |-> !accept && state_ff == ST_IDLE)
      else $error("request taken during palette sweep");

   a_accept_advances: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_FRAME)
      else $error("accepted request did not start");

endmodule

@@ tb/video_core_checker.sv @@
module video_core_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [bpfv_pkg::MODE_W-1:0] req_mode,
   input  logic [bpfv_pkg::ADDR_W-1:0] req_address,
   input  logic [bpfv_pkg::DATA_W-1:0] req_write_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [bpfv_pkg::DATA_W-1:0] rsp_read_data,
   input  logic [bpfv_pkg::DATA_W-1:0] rsp_red,
   input  logic [bpfv_pkg::DATA_W-1:0] rsp_green,
   input  logic [bpfv_pkg::DATA_W-1:0] rsp_blue,
   output int                          errors,
   output int                          outstanding
);

   typedef struct packed {
      logic [bpfv_pkg::DATA_W-1:0] read_data;
      logic [bpfv_pkg::DATA_W-1:0] red;
      logic [bpfv_pkg::DATA_W-1:0] green;
      logic [bpfv_pkg::DATA_W-1:0] blue;
   } reply_type;

   // two color bits over two intensity bits
   localparam logic [bpfv_pkg::DATA_W-1:0] INTENSITY_LUT [16] = '{
      8'h00, 8'h12, 8'h24, 8'h49,
      8'h12, 8'h24, 8'h49, 8'h92,
      8'h5b, 8'h6d, 8'h92, 8'hdb,
      8'h7f, 8'h91, 8'hb6, 8'hff
   };

   logic [bpfv_pkg::DATA_W-1:0] frame_img [0:65535];
   logic [bpfv_pkg::DATA_W-1:0] pal_img [0:bpfv_pkg::PAL_DEPTH-1];
   logic [bpfv_pkg::DATA_W-1:0] lat_hi;
   logic [bpfv_pkg::DATA_W-1:0] lat_lo;
   logic [bpfv_pkg::DATA_W-1:0] bank;
   reply_type                   reply_queue [$];

   function automatic logic [bpfv_pkg::DATA_W-1:0] color_level(
         input logic [bpfv_pkg::DATA_W-1:0] v, input int pos);
      logic [1:0] bits;
      bits = 2'(v >> pos);
      return INTENSITY_LUT[{bits, v[1:0]}];
   endfunction

   // Advance the shadow state by one request and return the reply it should produce.
   function automatic reply_type predict_reply(input logic [bpfv_pkg::MODE_W-1:0] mode,
                                               input logic [bpfv_pkg::ADDR_W-1:0] addr,
                                               input logic [bpfv_pkg::DATA_W-1:0] data);
      reply_type                   r;
      logic [bpfv_pkg::DATA_W-1:0] color;
      r = '0;
      case (mode)
         bpfv_pkg::MODE_WIN_RD:   r.read_data = frame_img[{lat_hi[7], addr[14:0]}];
         bpfv_pkg::MODE_WIN_WR:   frame_img[{lat_hi[7], addr[14:0]}] = data;
         bpfv_pkg::MODE_LATCH_RD: r.read_data = frame_img[{lat_hi, lat_lo}];
         bpfv_pkg::MODE_LATCH_WR: frame_img[{lat_hi, lat_lo}] = data;
         bpfv_pkg::MODE_LATCH_HI: lat_hi = data;
         bpfv_pkg::MODE_LATCH_LO: lat_lo = data;
         bpfv_pkg::MODE_PAL_WR:   pal_img[addr[bpfv_pkg::PAL_ADDR_W-1:0]] = data;
         bpfv_pkg::MODE_BANK_WR:  bank = data;
         bpfv_pkg::MODE_PIXEL: begin
            color = pal_img[{bank[1:0], frame_img[addr]}];
            r.red = color_level(color, 6);
            r.green = color_level(color, 4);
            r.blue = color_level(color, 2);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [bpfv_pkg::DATA_W-1:0] want,
                              input logic [bpfv_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      int        i;
      if (reset) begin
         lat_hi = '0;
         lat_lo = '0;
         bank = '0;
         for (i = 0; i < bpfv_pkg::PAL_DEPTH; i++) pal_img[i] = '0;
         reply_queue.delete();
         errors = 0;
      end else begin
         // a reply never belongs to a request taken on the same edge, so pop first
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual %h %h %h %h",
                        $time, rsp_read_data, rsp_red, rsp_green, rsp_blue);
               errors++;
            end else begin
               want = reply_queue.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("red", want.red, rsp_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
            end
         end
         if (req_valid && req_ready)
            reply_queue.push_back(predict_reply(req_mode, req_address, req_write_data));
      end
      outstanding = reply_queue.size();
   end

endmodule

@@ tb/testbench.sv @@
module testbench;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 400;
   localparam int LONG_HOLD = 300;
   localparam int QUIET_TAIL = 80;
   localparam int DRAIN_CYCLES = 16;
   localparam int TIMEOUT = 2400000;
   localparam logic [bpfv_pkg::MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [bpfv_pkg::MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [bpfv_pkg::MODE_W-1:0] req_mode;
   logic [bpfv_pkg::ADDR_W-1:0] req_address;
   logic [bpfv_pkg::DATA_W-1:0] req_write_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [bpfv_pkg::DATA_W-1:0] rsp_read_data;
   logic [bpfv_pkg::DATA_W-1:0] rsp_red;
   logic [bpfv_pkg::DATA_W-1:0] rsp_green;
   logic [bpfv_pkg::DATA_W-1:0] rsp_blue;
   int                          errors;
   int                          outstanding;

   bit                          tx_idle;
   bit                          rx_idle;
   bit                          stall_long;
   int                          items_sent;
   int                          mid_mark;

   // which frame bytes hold a value, tracked in request order
   bit                          written_map [0:65535];
   logic [bpfv_pkg::ADDR_W-1:0] written_list [$];
   logic [bpfv_pkg::DATA_W-1:0] lat_hi_sh;
   logic [bpfv_pkg::DATA_W-1:0] lat_lo_sh;

   banked_palette_framebuffer_video_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   video_core_checker monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .errors         (errors),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #TIMEOUT;
      $display("banked_palette_framebuffer_video_core test failed");
      $finish;
   end

   task automatic mark_written(input logic [bpfv_pkg::ADDR_W-1:0] a);
      if (!written_map[a]) begin
         written_map[a] = 1'b1;
         written_list.push_back(a);
      end
   endtask

   task automatic pick_written(input bit match_half, input bit half,
                               output logic [bpfv_pkg::ADDR_W-1:0] a, output bit ok);
      int                          k;
      logic [bpfv_pkg::ADDR_W-1:0] c;
      ok = 1'b0;
      a = '0;
      if (written_list.size() == 0) return;
      for (k = 0; k < 24 && !ok; k++) begin
         c = written_list[$urandom_range(0, written_list.size() - 1)];
         if (!match_half || c[15] == half) begin
            a = c;
            ok = 1'b1;
         end
      end
   endtask

   task automatic send_beat(input logic [bpfv_pkg::MODE_W-1:0] m,
                            input logic [bpfv_pkg::ADDR_W-1:0] a,
                            input logic [bpfv_pkg::DATA_W-1:0] d);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_mode = m;
      req_address = a;
      req_write_data = d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (m)
         bpfv_pkg::MODE_WIN_WR:   mark_written({lat_hi_sh[7], a[14:0]});
         bpfv_pkg::MODE_LATCH_WR: mark_written({lat_hi_sh, lat_lo_sh});
         bpfv_pkg::MODE_LATCH_HI: lat_hi_sh = d;
         bpfv_pkg::MODE_LATCH_LO: lat_lo_sh = d;
         default: ;
      endcase
      items_sent++;
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Hold off the sender until every reply is back, then let the pipeline settle.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic rand_item();
      int                          sel;
      bit                          ok;
      logic [bpfv_pkg::ADDR_W-1:0] a;
      logic [bpfv_pkg::DATA_W-1:0] pen;
      logic [1:0]                  page;
      sel = $urandom_range(0, 99);
      if (sel < 16) begin
         send_beat(bpfv_pkg::MODE_WIN_WR, 16'($urandom), 8'($urandom));
      end else if (sel < 30) begin
         pick_written(1'b1, lat_hi_sh[7], a, ok);
         if (ok) send_beat(bpfv_pkg::MODE_WIN_RD, {1'($urandom), a[14:0]}, 8'($urandom));
         else send_beat(bpfv_pkg::MODE_WIN_WR, 16'($urandom), 8'($urandom));
      end else if (sel < 44) begin
         // point the latch somewhere, then go through it
         ok = 1'b0;
         a = 16'($urandom);
         if ($urandom_range(0, 1)) pick_written(1'b0, 1'b0, a, ok);
         if (!ok) a = 16'($urandom);
         send_beat(bpfv_pkg::MODE_LATCH_HI, 16'($urandom), a[15:8]);
         send_beat(bpfv_pkg::MODE_LATCH_LO, 16'($urandom), a[7:0]);
         if (!ok) send_beat(bpfv_pkg::MODE_LATCH_WR, 16'($urandom), 8'($urandom));
         send_beat(bpfv_pkg::MODE_LATCH_RD, 16'($urandom), 8'($urandom));
      end else if (sel < 50) begin
         send_beat(bpfv_pkg::MODE_LATCH_HI, 16'($urandom), 8'($urandom));
      end else if (sel < 54) begin
         send_beat(bpfv_pkg::MODE_LATCH_LO, 16'($urandom), 8'($urandom));
      end else if (sel < 60) begin
         if (written_map[{lat_hi_sh, lat_lo_sh}] && $urandom_range(0, 1))
            send_beat(bpfv_pkg::MODE_LATCH_RD, 16'($urandom), 8'($urandom));
         else
            send_beat(bpfv_pkg::MODE_LATCH_WR, 16'($urandom), 8'($urandom));
      end else if (sel < 70) begin
         send_beat(bpfv_pkg::MODE_PAL_WR, 16'($urandom), 8'($urandom));
      end else if (sel < 74) begin
         send_beat(bpfv_pkg::MODE_BANK_WR, 16'($urandom), 8'($urandom));
      end else if (sel < 80) begin
         // place a pen, give it a color on some page, select that page, look it up
         a = 16'($urandom);
         pen = 8'($urandom);
         page = 2'($urandom);
         send_beat(bpfv_pkg::MODE_LATCH_HI, 16'($urandom), a[15:8]);
         send_beat(bpfv_pkg::MODE_LATCH_LO, 16'($urandom), a[7:0]);
         send_beat(bpfv_pkg::MODE_LATCH_WR, 16'($urandom), pen);
         send_beat(bpfv_pkg::MODE_PAL_WR, {6'($urandom), page, pen}, 8'($urandom));
         send_beat(bpfv_pkg::MODE_BANK_WR, 16'($urandom), {6'($urandom), page});
         send_beat(bpfv_pkg::MODE_PIXEL, a, 8'($urandom));
      end else if (sel < 94) begin
         pick_written(1'b0, 1'b0, a, ok);
         if (ok) send_beat(bpfv_pkg::MODE_PIXEL, a, 8'($urandom));
         else send_beat(bpfv_pkg::MODE_WIN_WR, 16'($urandom), 8'($urandom));
      end else begin
         send_beat(4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), 16'($urandom),
                   8'($urandom));
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_long) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            stall_long = 1'b0;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = bpfv_pkg::MODE_WIN_RD;
      req_address = '0;
      req_write_data = '0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      stall_long = 1'b0;
      items_sent = 0;
      lat_hi_sh = '0;
      lat_lo_sh = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: window halves, oversize offsets, latch extremes, palette and bank
      send_beat(bpfv_pkg::MODE_WIN_WR, 16'h0000, 8'hff);
      send_beat(bpfv_pkg::MODE_WIN_RD, 16'h8000, 8'h00);
      send_beat(bpfv_pkg::MODE_WIN_WR, 16'hffff, 8'h00);
      send_beat(bpfv_pkg::MODE_WIN_RD, 16'h7fff, 8'hff);
      send_beat(bpfv_pkg::MODE_PIXEL, 16'h0000, 8'h00);
      send_beat(bpfv_pkg::MODE_LATCH_HI, 16'h0000, 8'h80);
      send_beat(bpfv_pkg::MODE_WIN_WR, 16'h1234, 8'ha5);
      send_beat(bpfv_pkg::MODE_WIN_RD, 16'h9234, 8'h00);
      send_beat(bpfv_pkg::MODE_LATCH_HI, 16'h0000, 8'h92);
      send_beat(bpfv_pkg::MODE_LATCH_LO, 16'h0000, 8'h34);
      send_beat(bpfv_pkg::MODE_LATCH_RD, 16'h0000, 8'h00);
      send_beat(bpfv_pkg::MODE_LATCH_WR, 16'hffff, 8'h5a);
      send_beat(bpfv_pkg::MODE_LATCH_RD, 16'hffff, 8'hff);
      send_beat(bpfv_pkg::MODE_LATCH_HI, 16'h0000, 8'hff);
      send_beat(bpfv_pkg::MODE_LATCH_LO, 16'h0000, 8'hff);
      send_beat(bpfv_pkg::MODE_LATCH_WR, 16'h0000, 8'hc3);
      send_beat(bpfv_pkg::MODE_LATCH_RD, 16'h0000, 8'h00);
      send_beat(bpfv_pkg::MODE_PAL_WR, 16'hffff, 8'hff);
      send_beat(bpfv_pkg::MODE_BANK_WR, 16'h0000, 8'hff);
      send_beat(bpfv_pkg::MODE_PIXEL, 16'h0000, 8'h00);
      send_beat(bpfv_pkg::MODE_PAL_WR, 16'h035a, 8'he4);
      send_beat(bpfv_pkg::MODE_PIXEL, 16'h9234, 8'h00);
      send_beat(bpfv_pkg::MODE_BANK_WR, 16'h0000, 8'h04);
      send_beat(bpfv_pkg::MODE_PIXEL, 16'hffff, 8'h00);
      send_beat(MODE_UNUSED_HI, 16'hffff, 8'hff);
      send_beat(MODE_UNUSED_LO, 16'h0000, 8'h00);
      drain();

      mid_mark = items_sent + RANDOM_ITEMS;
      while (items_sent < mid_mark - 280) rand_item();
      // let the block back up against a stalled receiver
      stall_long = 1'b1;
      while (items_sent < mid_mark - 220) rand_item();
      while (items_sent < mid_mark - 150) rand_item();
      drain();
      while (items_sent < mid_mark - QUIET_TAIL) rand_item();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      while (items_sent < mid_mark) rand_item();
      drain();

      if (errors == 0) begin
         $display("banked_palette_framebuffer_video_core test passed");
      end else begin
         $display("banked_palette_framebuffer_video_core test failed");
      end
      $finish;
   end

endmodule
